// File: hw/rtl/mohv_pkg.sv
// Shared types, constants and helper functions for the offset histogram voter.
// No dependencies; every other file refers to this package by scoped names.
package mohv_pkg;

  localparam int MAX_SIZE   = 1024;
  localparam int FRAC_BITS  = 4;
  localparam int COUNT_BITS = 16;

  localparam int COORD_W = 14;
  localparam int SIZE_W  = 11;
  localparam int OUT_W   = 12;
  localparam int DEPTH   = 2 * MAX_SIZE + 2;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int EFF_W   = $clog2(MAX_SIZE + 1);
  localparam int BIN_W   = ((COORD_W > ADDR_W) ? COORD_W : ADDR_W) + 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_IMG_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMG_HEIGHT = 1'd1;

  typedef enum logic {
    REQ_VOTE   = 1'b0,
    REQ_REPORT = 1'b1
  } req_type_t;

  typedef struct packed {
    req_type_t          req_type;
    logic [COORD_W-1:0] x_first;
    logic [COORD_W-1:0] y_first;
    logic [COORD_W-1:0] x_second;
    logic [COORD_W-1:0] y_second;
  } vote_beat_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] offset_x;
    logic signed [OUT_W-1:0] offset_y;
  } result_beat_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_VOTE_RD,
    ST_VOTE_WR,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic latch_vote;
    logic latch_report;
    logic vote_read;
    logic vote_write;
    logic sweep_clear;
    logic sweep_scan;
    logic load_result;
  } dp_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic slot_free;
  } dp_status_t;

  typedef struct packed {
    logic              ok;
    logic [ADDR_W-1:0] idx;
  } bin_t;

  function automatic logic [EFF_W-1:0] eff_size(input logic [SIZE_W-1:0] size_reg);
    logic [EFF_W-1:0] s;
    if (32'(size_reg) > 32'(MAX_SIZE)) begin
      s = EFF_W'(MAX_SIZE);
    end else begin
      s = EFF_W'(size_reg);
    end
    return s;
  endfunction

  function automatic bin_t axis_bin(input logic [COORD_W-1:0] a,
                                    input logic [COORD_W-1:0] b,
                                    input logic [EFF_W-1:0]   size);
    logic signed [COORD_W:0] d;
    logic [COORD_W:0]        mag;
    logic signed [BIN_W-1:0] whole;
    logic signed [BIN_W-1:0] bin;
    logic signed [BIN_W-1:0] lim;
    bin_t                    r;
    d = $signed({1'b0, a}) - $signed({1'b0, b});
    if (d[COORD_W]) begin
      mag = (COORD_W + 1)'(-d);
    end else begin
      mag = (COORD_W + 1)'(d);
    end
    whole = $signed(BIN_W'(mag >> FRAC_BITS));
    if (d[COORD_W]) begin
      whole = -whole;
    end
    bin = whole + $signed(BIN_W'(size));
    lim = $signed(BIN_W'({size, 1'b1}));
    r.ok  = !bin[BIN_W-1] && (bin <= lim);
    r.idx = ADDR_W'(bin);
    return r;
  endfunction

endpackage

// File: hw/rtl/mohv_ctrl.sv
// Sequencer of the offset histogram voter: clearing pass, vote and report steps.
// Depends on mohv_pkg; drives the datapath through dp_cmd_t and reads dp_status_t.
module mohv_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                vote_valid,
  input  mohv_pkg::req_type_t req_type,
  input  mohv_pkg::dp_status_t status,
  output mohv_pkg::dp_cmd_t   cmd,
  output logic                vote_stall
);

  mohv_pkg::state_t state;
  mohv_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mohv_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    vote_stall = 1'b1;
    unique case (state)
      mohv_pkg::ST_INIT: begin
        cmd.sweep_clear = 1'b1;
        if (status.sweep_last) begin
          state_next = mohv_pkg::ST_IDLE;
        end
      end
      mohv_pkg::ST_IDLE: begin
        vote_stall = 1'b0;
        if (vote_valid) begin
          if (req_type == mohv_pkg::REQ_REPORT) begin
            cmd.latch_report = 1'b1;
            state_next       = mohv_pkg::ST_SCAN;
          end else begin
            cmd.latch_vote = 1'b1;
            state_next     = mohv_pkg::ST_VOTE_RD;
          end
        end
      end
      mohv_pkg::ST_VOTE_RD: begin
        cmd.vote_read = 1'b1;
        state_next    = mohv_pkg::ST_VOTE_WR;
      end
      mohv_pkg::ST_VOTE_WR: begin
        cmd.vote_write = 1'b1;
        state_next     = mohv_pkg::ST_IDLE;
      end
      mohv_pkg::ST_SCAN: begin
        cmd.sweep_scan = 1'b1;
        if (status.sweep_last) begin
          state_next = mohv_pkg::ST_DRAIN;
        end
      end
      mohv_pkg::ST_DRAIN: begin
        state_next = mohv_pkg::ST_DONE;
      end
      mohv_pkg::ST_DONE: begin
        if (status.slot_free) begin
          cmd.load_result = 1'b1;
          state_next      = mohv_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mohv_pkg::ST_INIT;
      end
    endcase
  end

endmodule

// File: hw/rtl/mohv_datapath.sv
// Datapath of the offset histogram voter: bin computation, the two count memories,
// the peak scan and the result register. Depends on mohv_pkg.
module mohv_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  mohv_pkg::dp_cmd_t             cmd,
  output mohv_pkg::dp_status_t          status,
  input  mohv_pkg::vote_beat_t          vote,
  input  logic [mohv_pkg::SIZE_W-1:0]   img_width,
  input  logic [mohv_pkg::SIZE_W-1:0]   img_height,
  input  logic                          result_stall,
  output logic                          result_valid,
  output mohv_pkg::result_beat_t        result
);

  logic [mohv_pkg::COUNT_BITS-1:0] x_mem [mohv_pkg::DEPTH];
  logic [mohv_pkg::COUNT_BITS-1:0] y_mem [mohv_pkg::DEPTH];

  logic [mohv_pkg::EFF_W-1:0]      w_eff;
  logic [mohv_pkg::EFF_W-1:0]      h_eff;
  mohv_pkg::bin_t                  bx;
  mohv_pkg::bin_t                  by;

  logic [mohv_pkg::ADDR_W-1:0]     bin_x;
  logic [mohv_pkg::ADDR_W-1:0]     bin_y;
  logic                            vote_ok;
  logic [mohv_pkg::EFF_W-1:0]      size_x;
  logic [mohv_pkg::EFF_W-1:0]      size_y;
  logic [mohv_pkg::ADDR_W-1:0]     lim_x;
  logic [mohv_pkg::ADDR_W-1:0]     lim_y;
  logic [mohv_pkg::ADDR_W-1:0]     cnt;
  logic                            scan_vld;
  logic [mohv_pkg::ADDR_W-1:0]     scan_addr;
  logic [mohv_pkg::COUNT_BITS-1:0] top_x;
  logic [mohv_pkg::COUNT_BITS-1:0] top_y;
  logic [mohv_pkg::ADDR_W-1:0]     best_x;
  logic [mohv_pkg::ADDR_W-1:0]     best_y;
  logic [mohv_pkg::COUNT_BITS-1:0] x_rd;
  logic [mohv_pkg::COUNT_BITS-1:0] y_rd;

  logic [mohv_pkg::ADDR_W-1:0]     x_addr;
  logic [mohv_pkg::ADDR_W-1:0]     y_addr;
  logic [mohv_pkg::COUNT_BITS-1:0] x_wdata;
  logic [mohv_pkg::COUNT_BITS-1:0] y_wdata;
  logic                            mem_we;
  logic                            sweep;
  logic signed [mohv_pkg::ADDR_W:0] diff_x;
  logic signed [mohv_pkg::ADDR_W:0] diff_y;

  assign w_eff = mohv_pkg::eff_size(img_width);
  assign h_eff = mohv_pkg::eff_size(img_height);
  assign bx    = mohv_pkg::axis_bin(vote.x_first, vote.x_second, w_eff);
  assign by    = mohv_pkg::axis_bin(vote.y_first, vote.y_second, h_eff);

  assign sweep             = cmd.sweep_clear || cmd.sweep_scan;
  assign status.sweep_last = (cnt == mohv_pkg::ADDR_W'(mohv_pkg::DEPTH - 1));
  assign status.slot_free  = !result_valid || !result_stall;

  // Votes use the latched bins; sweeps walk every entry and leave zeros behind.
  assign x_addr = (cmd.vote_read || cmd.vote_write) ? bin_x : cnt;
  assign y_addr = (cmd.vote_read || cmd.vote_write) ? bin_y : cnt;
  assign x_wdata = !cmd.vote_write ? '0 :
                   (x_rd == '1) ? x_rd : x_rd + mohv_pkg::COUNT_BITS'(1);
  assign y_wdata = !cmd.vote_write ? '0 :
                   (y_rd == '1) ? y_rd : y_rd + mohv_pkg::COUNT_BITS'(1);
  assign mem_we  = (cmd.vote_write && vote_ok) || sweep;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      x_mem[x_addr] <= x_wdata;
    end
    x_rd <= x_mem[x_addr];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      y_mem[y_addr] <= y_wdata;
    end
    y_rd <= y_mem[y_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_vote) begin
      bin_x   <= bx.idx;
      bin_y   <= by.idx;
      vote_ok <= bx.ok && by.ok;
    end
    if (cmd.latch_report) begin
      size_x <= w_eff;
      size_y <= h_eff;
      lim_x  <= mohv_pkg::ADDR_W'({w_eff, 1'b1});
      lim_y  <= mohv_pkg::ADDR_W'({h_eff, 1'b1});
    end
    scan_addr <= cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      scan_vld <= 1'b0;
    end else begin
      scan_vld <= cmd.sweep_scan;
      if (cmd.latch_report) begin
        cnt <= '0;
      end else if (sweep) begin
        cnt <= status.sweep_last ? '0 : cnt + mohv_pkg::ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_report) begin
      top_x  <= '0;
      top_y  <= '0;
      best_x <= '0;
      best_y <= '0;
    end else if (scan_vld) begin
      if ((scan_addr <= lim_x) && (x_rd > top_x)) begin
        top_x  <= x_rd;
        best_x <= scan_addr;
      end
      if ((scan_addr <= lim_y) && (y_rd > top_y)) begin
        top_y  <= y_rd;
        best_y <= scan_addr;
      end
    end
  end

  assign diff_x = $signed({1'b0, best_x}) - $signed({1'b0, mohv_pkg::ADDR_W'(size_x)});
  assign diff_y = $signed({1'b0, best_y}) - $signed({1'b0, mohv_pkg::ADDR_W'(size_y)});

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      result.offset_x <= mohv_pkg::OUT_W'(diff_x);
      result.offset_y <= mohv_pkg::OUT_W'(diff_y);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_result) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

endmodule

// File: hw/rtl/match_offset_histogram_vote.sv
// Top level of the offset histogram voter: size registers, sequencer and datapath.
// Depends on mohv_pkg, mohv_ctrl and mohv_datapath.
//
//   channel  direction  beat type      handshake
//   vote     in         vote_beat_t    vote_valid / vote_stall
//   result   out        result_beat_t  result_valid / result_stall
//   cfg      in         11-bit data    cfg_we, cfg_index
//
// A vote beat runs ST_VOTE_RD, then ST_VOTE_WR: one read and one write per histogram.
// A report beat sweeps every bin of both count memories, reading and clearing them
// one address per cycle, then passes through ST_DRAIN and ST_DONE.
// After reset the block clears every bin of both memories with vote_stall high.
// A finished result waits in the output register while result_stall is high.
module match_offset_histogram_vote (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             vote_valid,
  output logic                             vote_stall,
  input  mohv_pkg::vote_beat_t             vote,
  output logic                             result_valid,
  input  logic                             result_stall,
  output mohv_pkg::result_beat_t           result,
  input  logic                             cfg_we,
  input  logic [mohv_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mohv_pkg::SIZE_W-1:0]      cfg_data
);

  logic [mohv_pkg::SIZE_W-1:0] img_width;
  logic [mohv_pkg::SIZE_W-1:0] img_height;
  mohv_pkg::dp_cmd_t           cmd;
  mohv_pkg::dp_status_t        status;

  always_ff @(posedge clk) begin
    if (rst) begin
      img_width  <= mohv_pkg::SIZE_W'(640);
      img_height <= mohv_pkg::SIZE_W'(480);
    end else if (cfg_we) begin
      if (cfg_index == mohv_pkg::REG_IMG_WIDTH) begin
        img_width <= cfg_data;
      end else if (cfg_index == mohv_pkg::REG_IMG_HEIGHT) begin
        img_height <= cfg_data;
      end
    end
  end

  mohv_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .vote_valid (vote_valid),
    .req_type   (vote.req_type),
    .status     (status),
    .cmd        (cmd),
    .vote_stall (vote_stall)
  );

  mohv_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .vote         (vote),
    .img_width    (img_width),
    .img_height   (img_height),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule
